// ----- rtl/core/svau_pkg.sv -----
// Package for the sound voice allocator: request, response and voice-entry
// types, opcodes, back-end states and shared constants. No dependencies.
package svau_pkg;

  localparam int unsigned VOICES_DEF = 8;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [15:0] VIEWER_RST = 16'd1;
  localparam logic [31:0] LIFE_MAX   = 32'h7fff_ffff;
  localparam logic [3:0]  SUB_ANY    = 4'hF;
  localparam logic [3:0]  SUB_NONE   = 4'h0;
  localparam logic [3:0]  CNT_SAT    = 4'd15;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_STOP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        owner;
    logic signed [3:0]  sub_channel;
    logic [30:0]        now;
    logic [23:0]        length;
    logic               start_ok;
  } in_req_t;

  typedef struct packed {
    logic       found;
    logic [2:0] voice_index;
    logic       stole_active;
    logic [3:0] stopped_count;
  } out_rsp_t;

  // classified request as held in the queue
  typedef struct packed {
    logic        is_stop;
    logic        sub_zero;
    logic        sub_any;
    logic        guard;
    logic [15:0] owner;
    logic [3:0]  sub;
    logic [30:0] now;
    logic [23:0] length;
    logic        start_ok;
  } cmd_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [3:0]  slot;
    logic [31:0] end_t;
    logic        active;
  } voice_t;

endpackage

// ----- rtl/core/sound_voice_allocator_unit.sv -----
// Top level of the sound voice allocator: viewer register, front end with
// request queue, and scanning back end. Depends on svau_pkg, svau_front,
// svau_back.
//
// Usage:
//   Requests enter on in_valid_i/in_stall_o/in_req_i; a request is taken at
//   a clock edge with in_valid_i high and in_stall_o low. The front end
//   holds up to two requests, so requests are taken while the back end is
//   busy or a response waits. One response per request leaves on
//   out_valid_o/out_stall_i/out_rsp_o, in request order.
//   cfg_we_i writes cfg_wdata_i into the viewer owner register (reset 1);
//   write it only while no request is in flight.
//   An allocate scans the table and then writes the chosen voice; a stop
//   writes each matching entry while it scans. A stop on a nonzero
//   sub-channel ends at its first match. One voice entry is read per cycle
//   and a request starts only after the previous response left, so a new
//   request is not started before the last one is through.
//   Reset clears the voice table through per-entry valid bits at once; no
//   clearing pass is needed. While out_stall_i holds a response, the back
//   end waits and the queue fills, then in_stall_o rises.
module sound_voice_allocator_unit #(
  parameter int unsigned VOICES = svau_pkg::VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  svau_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output svau_pkg::out_rsp_t out_rsp_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  logic [15:0]    viewer_q;
  logic           q_valid, q_pop;
  svau_pkg::cmd_t q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewer_q <= svau_pkg::VIEWER_RST;
    end else if (cfg_we_i) begin
      viewer_q <= cfg_wdata_i;
    end
  end

  svau_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .viewer_i  (viewer_q),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  svau_back #(
    .VOICES(VOICES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .viewer_i   (viewer_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

// ----- rtl/core/svau_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module svau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/svau_front.sv -----
// Front end: accepts requests, classifies them and holds them in a short
// queue for the back end. Depends on svau_pkg.
module svau_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  svau_pkg::in_req_t in_req_i,
  input  logic [15:0]      viewer_i,
  output logic             q_valid_o,
  output svau_pkg::cmd_t   q_cmd_o,
  input  logic             q_pop_i
);

  localparam int unsigned PW = $clog2(svau_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(svau_pkg::QDEPTH + 1);

  svau_pkg::cmd_t q_mem_q [svau_pkg::QDEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  svau_pkg::cmd_t cmd;
  logic           push;

  always_comb begin
    cmd          = '0;
    cmd.is_stop  = (in_req_i.opcode == svau_pkg::OP_STOP);
    cmd.sub_zero = (in_req_i.sub_channel == svau_pkg::SUB_NONE);
    cmd.sub_any  = (in_req_i.sub_channel == svau_pkg::SUB_ANY);
    cmd.guard    = (in_req_i.owner != viewer_i);
    cmd.owner    = in_req_i.owner;
    cmd.sub      = in_req_i.sub_channel;
    cmd.now      = in_req_i.now;
    cmd.length   = in_req_i.length;
    cmd.start_ok = in_req_i.start_ok;
  end

  assign in_stall_o = (cnt_q == CW'(svau_pkg::QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_cmd_o    = q_mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(svau_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_d = (rd_q == PW'(svau_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= cmd;
    end
  end

endmodule

// ----- rtl/core/svau_back.sv -----
// Back end: scans the voice table one entry per cycle, writes back the
// chosen or stopped voices and registers the response. Depends on svau_pkg
// and svau_ram.
module svau_back #(
  parameter int unsigned VOICES = svau_pkg::VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  svau_pkg::cmd_t     q_cmd_i,
  output logic               q_pop_o,
  input  logic [15:0]        viewer_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output svau_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned IW = $clog2(VOICES);
  localparam int unsigned VW = $bits(svau_pkg::voice_t);

  svau_pkg::state_e   state_q, state_d;
  svau_pkg::cmd_t     cmd_q, cmd_d;
  logic [IW-1:0]      rd_q, rd_d, ev_idx_q, ev_idx_d, pick_q, pick_d;
  logic               rd_more_q, rd_more_d, ev_vld_q, ev_vld_d;
  logic signed [31:0] best_q, best_d;
  logic               found_q, found_d, act_q, act_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               out_vld_q, out_vld_d;
  svau_pkg::out_rsp_t rsp_q, rsp_d;
  logic [VOICES-1:0]  vb_q;
  logic               ent_vb_q;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  svau_pkg::voice_t   ram_wdata, ent;
  logic [VW-1:0]      ram_rdata;

  logic               hit, skip, match, brk, last, scan_end;
  logic signed [31:0] life;

  svau_ram #(
    .WIDTH(VW),
    .DEPTH(VOICES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // entries never written read as the reset value
  assign ent = ent_vb_q ? svau_pkg::voice_t'(ram_rdata) : '0;

  assign hit   = !cmd_q.sub_zero && (ent.owner == cmd_q.owner) &&
                 ((ent.slot == cmd_q.sub) || cmd_q.sub_any);
  assign skip  = (ent.owner == viewer_i) && cmd_q.guard && ent.active;
  assign life  = $signed(ent.end_t - {1'b0, cmd_q.now});
  assign match = (ent.owner == cmd_q.owner) &&
                 (cmd_q.sub_zero || (ent.slot == cmd_q.sub));
  assign brk   = ev_vld_q && ((!cmd_q.is_stop && hit) ||
                              (cmd_q.is_stop && match && !cmd_q.sub_zero));
  assign last  = ev_vld_q && (ev_idx_q == IW'(VOICES - 1));
  assign scan_end = (state_q == svau_pkg::ST_SCAN) && (brk || last);

  assign q_pop_o = (state_q == svau_pkg::ST_IDLE) && q_valid_i && !out_vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      svau_pkg::ST_IDLE: begin
        if (q_pop_o) begin
          state_d = svau_pkg::ST_SCAN;
        end
      end
      svau_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = cmd_q.is_stop ? svau_pkg::ST_IDLE : svau_pkg::ST_WRITE;
        end
      end
      svau_pkg::ST_WRITE: state_d = svau_pkg::ST_IDLE;
      default:            state_d = svau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    rd_d      = rd_q;
    rd_more_d = rd_more_q;
    ev_vld_d  = 1'b0;
    ev_idx_d  = ev_idx_q;
    pick_d    = pick_q;
    best_d    = best_q;
    found_d   = found_q;
    act_d     = act_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q && out_stall_i;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = ev_idx_q;
    ram_wdata = '0;
    ram_raddr = rd_q;
    case (state_q)
      svau_pkg::ST_IDLE: begin
        if (q_pop_o) begin
          cmd_d     = q_cmd_i;
          rd_d      = '0;
          rd_more_d = 1'b1;
          best_d    = svau_pkg::LIFE_MAX;
          pick_d    = '0;
          found_d   = 1'b0;
          act_d     = 1'b0;
          cnt_d     = '0;
        end
      end
      svau_pkg::ST_SCAN: begin
        if (rd_more_q) begin
          ev_vld_d = 1'b1;
          ev_idx_d = rd_q;
          if (rd_q == IW'(VOICES - 1)) begin
            rd_more_d = 1'b0;
          end else begin
            rd_d = rd_q + 1'b1;
          end
        end
        if (ev_vld_q) begin
          if (!cmd_q.is_stop) begin
            if (hit) begin
              found_d = 1'b1;
              pick_d  = ev_idx_q;
              act_d   = ent.active;
            end else if (!skip && (life < best_q)) begin
              best_d  = life;
              found_d = 1'b1;
              pick_d  = ev_idx_q;
              act_d   = ent.active;
            end
          end else if (match) begin
            ram_we          = 1'b1;
            ram_wdata.owner = ent.owner;
            ram_wdata.slot  = ent.slot;
            cnt_d = (cnt_q == svau_pkg::CNT_SAT) ? cnt_q : cnt_q + 1'b1;
            if (cnt_q == '0) begin
              pick_d = ev_idx_q;
            end
          end
        end
        if (scan_end) begin
          ev_vld_d  = 1'b0;
          rd_more_d = 1'b0;
          if (cmd_q.is_stop) begin
            out_vld_d           = 1'b1;
            rsp_d.found         = (cnt_d != '0);
            rsp_d.voice_index   = (cnt_d != '0) ? 3'(pick_d) : '0;
            rsp_d.stole_active  = 1'b0;
            rsp_d.stopped_count = cnt_d;
          end
        end
      end
      svau_pkg::ST_WRITE: begin
        ram_waddr        = pick_q;
        ram_we           = found_q;
        ram_wdata.owner  = cmd_q.owner;
        ram_wdata.slot   = cmd_q.sub;
        ram_wdata.active = cmd_q.start_ok;
        ram_wdata.end_t  = cmd_q.start_ok ?
                           (32'(cmd_q.now) + 32'(cmd_q.length)) : '0;
        out_vld_d           = 1'b1;
        rsp_d.found         = found_q;
        rsp_d.voice_index   = found_q ? 3'(pick_q) : '0;
        rsp_d.stole_active  = found_q && act_q;
        rsp_d.stopped_count = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= svau_pkg::ST_IDLE;
      rd_more_q <= 1'b0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      vb_q      <= '0;
    end else begin
      state_q   <= state_d;
      rd_more_q <= rd_more_d;
      ev_vld_q  <= ev_vld_d;
      out_vld_q <= out_vld_d;
      if (ram_we) begin
        vb_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rd_q     <= rd_d;
    ev_idx_q <= ev_idx_d;
    pick_q   <= pick_d;
    best_q   <= best_d;
    found_q  <= found_d;
    act_q    <= act_d;
    cnt_q    <= cnt_d;
    rsp_q    <= rsp_d;
    ent_vb_q <= vb_q[ram_raddr];
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- rtl/core/svau_chk.sv -----
// Port-level checker for sound_voice_allocator_unit, attached by bind.
// Depends on svau_pkg.
module svau_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input svau_pkg::out_rsp_t out_rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  a_no_find_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |->
      out_rsp_o.voice_index == '0 && !out_rsp_o.stole_active &&
      out_rsp_o.stopped_count == '0)
    else $error("empty response carries data");

  a_stop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.stopped_count != '0 |->
      out_rsp_o.found && !out_rsp_o.stole_active)
    else $error("stop response inconsistent");

  a_rsp_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("response right after a taken one");

endmodule

bind sound_voice_allocator_unit svau_chk u_chk (.*);

// ----- tb/sv/sound_voice_allocator_unit_tb.sv -----
// Testbench for sound_voice_allocator_unit: random and directed allocate/stop
// requests checked against a voice-table scoreboard, with random stalls.
// Depends on svau_pkg and the sound_voice_allocator_unit RTL.
`timescale 1ns / 1ps

module sound_voice_allocator_unit_tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = svau_pkg::VOICES_DEF + 8;
  localparam int PHASE_ITEMS  = 300;

  class voice_alloc_sb;
    logic [15:0]        viewer;
    logic [15:0]        v_owner[svau_pkg::VOICES_DEF];
    logic [3:0]         v_slot[svau_pkg::VOICES_DEF];
    logic [31:0]        v_end[svau_pkg::VOICES_DEF];
    logic               v_active[svau_pkg::VOICES_DEF];
    svau_pkg::out_rsp_t pending[$];
    int                 errors;

    function new();
      viewer = svau_pkg::VIEWER_RST;
      errors = 0;
      for (int i = 0; i < svau_pkg::VOICES_DEF; i++) begin
        v_owner[i]  = '0;
        v_slot[i]   = '0;
        v_end[i]    = '0;
        v_active[i] = 1'b0;
      end
    endfunction

    function void note_request(svau_pkg::in_req_t r);
      svau_pkg::out_rsp_t exp;
      logic [3:0]         sub;
      logic [31:0]        diff;
      int                 pick;
      int                 best;
      int                 life;
      int                 count;
      exp = '0;
      sub = r.sub_channel;
      if (svau_pkg::op_e'(r.opcode) == svau_pkg::OP_ALLOC) begin
        pick = -1;
        best = int'(svau_pkg::LIFE_MAX);
        for (int i = 0; i < svau_pkg::VOICES_DEF; i++) begin
          if (sub != svau_pkg::SUB_NONE && v_owner[i] == r.owner &&
              (v_slot[i] == sub || sub == svau_pkg::SUB_ANY)) begin
            pick = i;
            break;
          end
          if (v_owner[i] == viewer && r.owner != viewer && v_active[i])
            continue;
          diff = v_end[i] - {1'b0, r.now};
          life = int'($signed(diff));
          if (life < best) begin
            best = life;
            pick = i;
          end
        end
        if (pick >= 0) begin
          exp.found        = 1'b1;
          exp.voice_index  = 3'(pick);
          exp.stole_active = v_active[pick];
          v_owner[pick]    = r.owner;
          v_slot[pick]     = sub;
          v_active[pick]   = r.start_ok;
          v_end[pick]      = r.start_ok ? ({1'b0, r.now} + {8'd0, r.length}) : '0;
        end
      end else begin
        count = 0;
        for (int i = 0; i < svau_pkg::VOICES_DEF; i++) begin
          if (v_owner[i] == r.owner &&
              (sub == svau_pkg::SUB_NONE || v_slot[i] == sub)) begin
            v_end[i]    = '0;
            v_active[i] = 1'b0;
            if (count == 0) exp.voice_index = 3'(i);
            if (count < int'(svau_pkg::CNT_SAT)) count++;
            if (sub != svau_pkg::SUB_NONE) break;
          end
        end
        exp.found         = (count != 0);
        exp.stopped_count = 4'(count);
      end
      pending.push_back(exp);
    endfunction

    function void field_check(string name, logic [3:0] exp_v, logic [3:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_response(svau_pkg::out_rsp_t got);
      svau_pkg::out_rsp_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: response with no request pending, expected none, got %h",
                 $time, got);
        return;
      end
      exp = pending.pop_front();
      field_check("found", 4'(exp.found), 4'(got.found));
      field_check("voice_index", 4'(exp.voice_index), 4'(got.voice_index));
      field_check("stole_active", 4'(exp.stole_active), 4'(got.stole_active));
      field_check("stopped_count", exp.stopped_count, got.stopped_count);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  svau_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  svau_pkg::out_rsp_t out_rsp_o;
  logic               cfg_we_i;
  logic [15:0]        cfg_wdata_i;

  voice_alloc_sb sb;
  logic [30:0]   play_time;
  bit            idle_on;
  bit            hold_req;
  int            hold_left;
  int            stall_left;
  int            cycle_count;

  always #5 clk_i = ~clk_i;

  sound_voice_allocator_unit #(
    .VOICES(svau_pkg::VOICES_DEF)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [15:0] pick_owner();
    case ($urandom_range(0, 9))
      0, 1, 2: return sb.viewer;
      3, 4:    return 16'd2;
      5:       return 16'd3;
      6:       return 16'd5;
      7:       return 16'hFFFF;
      8:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic svau_pkg::in_req_t rand_request();
    svau_pkg::in_req_t r;
    int                k;
    r.opcode = ($urandom_range(0, 99) < 25) ? svau_pkg::OP_STOP : svau_pkg::OP_ALLOC;
    r.owner  = pick_owner();
    k = $urandom_range(0, 9);
    if (k < 8) begin
      r.sub_channel = ($urandom_range(0, 8) == 8) ? svau_pkg::SUB_ANY :
                      4'($urandom_range(0, 7));
    end else begin
      r.sub_channel = 4'($urandom_range(0, 15));
    end
    if ($urandom_range(0, 49) == 0) play_time = 31'($urandom);
    else play_time = play_time + 31'($urandom_range(0, 2000));
    r.now = play_time;
    k = $urandom_range(0, 99);
    if (k < 70) r.length = 24'($urandom_range(0, 5000));
    else if (k < 95) r.length = 24'($urandom);
    else r.length = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
    r.start_ok = ($urandom_range(0, 99) < 85);
    return r;
  endfunction

  task automatic send_request(svau_pkg::in_req_t r);
    int gap;
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(svau_pkg::op_e op, logic [15:0] own, logic [3:0] sub,
                             logic [30:0] now_v, logic [23:0] len, logic ok);
    svau_pkg::in_req_t r;
    r.opcode      = op;
    r.owner       = own;
    r.sub_channel = sub;
    r.now         = now_v;
    r.length      = len;
    r.start_ok    = ok;
    send_request(r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_viewer(logic [15:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.viewer = v;
  endtask

  task automatic run_random(int n);
    repeat (n) send_request(rand_request());
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = idle_on ? pick_gap() : 0;
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    play_time   = '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    hold_left   = 0;
    stall_left  = 0;
    cycle_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // viewer at reset value; fill the table with protected viewer voices
    for (int k = 0; k < svau_pkg::VOICES_DEF; k++)
      send_fields(svau_pkg::OP_ALLOC, 16'd1, svau_pkg::SUB_NONE, 31'(k * 10),
                  24'd1000, 1'b1);
    send_fields(svau_pkg::OP_ALLOC, 16'd2, 4'd1, 31'd100, 24'd50, 1'b1);
    send_fields(svau_pkg::OP_ALLOC, 16'd1, svau_pkg::SUB_ANY, 31'd100, 24'd20, 1'b1);
    send_fields(svau_pkg::OP_ALLOC, 16'd1, 4'd3, 31'd200, 24'd0, 1'b0);
    send_fields(svau_pkg::OP_ALLOC, 16'd2, 4'd5, 31'h7FFFFFFF, 24'hFFFFFF, 1'b1);
    send_fields(svau_pkg::OP_ALLOC, 16'd2, 4'd5, 31'h7FFFFFFF, 24'd10, 1'b1);
    send_fields(svau_pkg::OP_ALLOC, 16'hFFFF, 4'd7, 31'd0, 24'hFFFFFF, 1'b1);
    send_fields(svau_pkg::OP_ALLOC, 16'h0000, 4'h8, 31'd5, 24'd1, 1'b1);
    send_fields(svau_pkg::OP_STOP, 16'd1, svau_pkg::SUB_NONE, 31'd300, 24'd0, 1'b0);
    send_fields(svau_pkg::OP_STOP, 16'd2, 4'd5, 31'd300, 24'd0, 1'b0);
    send_fields(svau_pkg::OP_STOP, 16'd1, svau_pkg::SUB_ANY, 31'd300, 24'd0, 1'b0);
    send_fields(svau_pkg::OP_STOP, 16'd3, svau_pkg::SUB_NONE, 31'd300, 24'd0, 1'b0);
    send_fields(svau_pkg::OP_STOP, 16'hFFFF, 4'd7, 31'h7FFFFFFF, 24'hFFFFFF, 1'b1);
    send_fields(svau_pkg::OP_ALLOC, 16'h0000, svau_pkg::SUB_NONE, 31'h7FFFFFFF,
                24'd0, 1'b0);
    wait_idle();

    set_viewer(16'h0000);
    run_random(PHASE_ITEMS);
    wait_idle();

    // back-to-back requests against a long output hold-off
    set_viewer(16'hFFFF);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    run_random(PHASE_ITEMS);
    wait_idle();
    idle_on = 1'b1;

    set_viewer(16'd2);
    run_random(PHASE_ITEMS);
    wait_idle();

    set_viewer(16'($urandom));
    run_random(PHASE_ITEMS);
    wait_idle();

    set_viewer(16'd1);
    run_random(PHASE_ITEMS);
    wait_idle();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sound_voice_allocator_unit.f -----
rtl/core/svau_pkg.sv
rtl/core/svau_ram.sv
rtl/core/svau_front.sv
rtl/core/svau_back.sv
rtl/core/sound_voice_allocator_unit.sv
rtl/core/svau_chk.sv
tb/sv/sound_voice_allocator_unit_tb.sv
